// ----- src/dqs_pkg.sv -----
// Shared constants, operation and status codes for the bounded deque with search.
// Also holds the ring slot helper. No dependencies.
`timescale 1ns / 1ps

package dqs_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam int VAL_W    = 32;
	localparam int OP_W     = 3;
	localparam int STAT_W   = 2;
	localparam int OCC_W    = 7;
	localparam int OUT_RAW_W = VAL_W + 1 + STAT_W + OCC_W;
	localparam int OUT_W    = ((OUT_RAW_W + 7) / 8) * 8;

	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OP_W-1:0] OP_DELETE     = 3'd4;
	localparam logic [OP_W-1:0] OP_SEARCH     = 3'd5;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	// Ring slot of a position counted from the front; the wrap subtracts CAPACITY at most once.
	function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] base,
			input logic [CNT_W-1:0] pos);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(base) + {1'b0, pos};
		if (sum >= (CNT_W+1)'(CAPACITY)) begin
			sum = sum - (CNT_W+1)'(CAPACITY);
		end
		return sum[ADDR_W-1:0];
	endfunction

endpackage

// ----- src/bounded_deque_with_search_core.sv -----
// Top level of the bounded deque with search and delete.
// Depends on dqs_pkg and dqs_ram.
`timescale 1ns / 1ps

// Usage:
//   Slave stream: s_tuser carries the operation code, s_tdata the 32-bit value.
//   Master stream: one result transfer per accepted operation, in order.
//   Entries live in a single RAM with registered read; a sequencer
//   reads, compares and writes back through its one read and one write port.
// Operation flow:
//   push: one RAM write; pop: one RAM read.
//   search: scans from the front, one entry compared per cycle from the read port.
//   delete: the scan is followed by a gap-closing pass that
//   moves one entry per cycle (read slot j+1, write slot j in the cycle after).
//   Operations are taken one at a time; s_tready is high while the sequencer idles.
// Reset: arst_n clears front index, count and the handshakes; the empty store
//   holds nothing visible, so RAM contents need no clearing.
// Stall: a finished result waits in the output register; the next operation is
//   accepted and executed meanwhile, and its result holds until the register frees.

module bounded_deque_with_search_core
	import dqs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [31:0]      s_tdata,   // [31:0] value
	input  logic [OP_W-1:0]  s_tuser,   // [2:0] op
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata    // [31:0] popped_value, [32] found,
	                                    // [34:33] status, [41:35] occupancy, rest zero
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_POP   = 5'b00010,
		S_SCAN  = 5'b00100,
		S_SHIFT = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t                   state_q;
	logic [ADDR_W-1:0]        front_q;
	logic [CNT_W-1:0]         count_q;
	logic [OP_W-1:0]          op_q;
	logic signed [VAL_W-1:0]  val_q;

	logic signed [VAL_W-1:0]  res_popped_q;
	logic                     res_found_q;
	logic [STAT_W-1:0]        res_status_q;

	logic [CNT_W-1:0]         issue_pos_q;
	logic [CNT_W-1:0]         chk_pos_s1;
	logic                     chk_vld_s1;
	logic [CNT_W-1:0]         sh_rd_q;
	logic [CNT_W-1:0]         sh_dst_s1;
	logic                     sh_vld_s1;

	logic                     m_tvalid_q;
	logic [OUT_W-1:0]         m_tdata_q;

	logic                     ram_we;
	logic [ADDR_W-1:0]        ram_waddr;
	logic [VAL_W-1:0]         ram_wdata;
	logic [ADDR_W-1:0]        ram_raddr;
	logic [VAL_W-1:0]         ram_rdata;

	logic                     accept;
	logic                     is_full;
	logic                     is_empty;
	logic [ADDR_W-1:0]        front_dec;
	logic [ADDR_W-1:0]        front_inc;
	logic                     scan_hit;
	logic                     out_free;

	assign accept    = s_tvalid && (state_q == S_IDLE);
	assign s_tready  = (state_q == S_IDLE);
	assign is_full   = (count_q == CNT_W'(CAPACITY));
	assign is_empty  = (count_q == '0);
	assign front_dec = (front_q == '0) ? ADDR_W'(CAPACITY - 1) : front_q - ADDR_W'(1);
	assign front_inc = (front_q == ADDR_W'(CAPACITY - 1)) ? '0 : front_q + ADDR_W'(1);
	assign scan_hit  = chk_vld_s1 && (ram_rdata == val_q);
	assign out_free  = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Read and write port steering
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_of(front_q, sh_dst_s1);
		ram_wdata = ram_rdata;
		ram_raddr = slot_of(front_q, issue_pos_q);
		unique case (state_q)
			S_IDLE: begin
				if (s_tuser == OP_POP_FRONT) begin
					ram_raddr = front_q;
				end else begin
					ram_raddr = slot_of(front_q, count_q - CNT_W'(1));
				end
				if (accept && !is_full) begin
					if (s_tuser == OP_PUSH_FRONT) begin
						ram_we    = 1'b1;
						ram_waddr = front_dec;
						ram_wdata = s_tdata;
					end else if (s_tuser == OP_PUSH_BACK) begin
						ram_we    = 1'b1;
						ram_waddr = slot_of(front_q, count_q);
						ram_wdata = s_tdata;
					end
				end
			end
			S_SCAN: begin
				ram_raddr = slot_of(front_q, issue_pos_q);
			end
			S_SHIFT: begin
				ram_raddr = slot_of(front_q, sh_rd_q);
				ram_we    = sh_vld_s1;
			end
			S_POP, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	dqs_ram #(
		.WIDTH(VAL_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q         <= s_tuser;
					val_q        <= s_tdata;
					res_popped_q <= '0;
					res_found_q  <= 1'b0;
					res_status_q <= STAT_OK;
					issue_pos_q  <= '0;
					case (s_tuser)
						OP_PUSH_FRONT, OP_PUSH_BACK: begin
							if (is_full) begin
								res_status_q <= STAT_FULL;
							end
						end
						OP_POP_FRONT, OP_POP_BACK, OP_DELETE, OP_SEARCH: begin
							if (is_empty) begin
								res_status_q <= STAT_EMPTY;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_POP: begin
				res_popped_q <= ram_rdata;
			end
			S_SCAN: begin
				chk_pos_s1 <= issue_pos_q;
				if (issue_pos_q < count_q) begin
					issue_pos_q <= issue_pos_q + CNT_W'(1);
				end
				if (scan_hit) begin
					res_found_q <= 1'b1;
					sh_rd_q     <= chk_pos_s1 + CNT_W'(1);
				end
			end
			S_SHIFT: begin
				sh_dst_s1 <= sh_rd_q - CNT_W'(1);
				if (sh_rd_q < count_q) begin
					sh_rd_q <= sh_rd_q + CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer, pointers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			front_q    <= '0;
			count_q    <= '0;
			chk_vld_s1 <= 1'b0;
			sh_vld_s1  <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			// The done state reloads the register itself
			if (m_tvalid_q && m_tready && (state_q != S_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					chk_vld_s1 <= 1'b0;
					if (accept) begin
						state_q <= S_DONE;
						case (s_tuser)
							OP_PUSH_FRONT: begin
								if (!is_full) begin
									front_q <= front_dec;
									count_q <= count_q + CNT_W'(1);
								end
							end
							OP_PUSH_BACK: begin
								if (!is_full) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							OP_POP_FRONT, OP_POP_BACK: begin
								if (!is_empty) begin
									state_q <= S_POP;
								end
							end
							OP_DELETE, OP_SEARCH: begin
								if (!is_empty) begin
									state_q <= S_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_POP: begin
					if (op_q == OP_POP_FRONT) begin
						front_q <= front_inc;
					end
					count_q <= count_q - CNT_W'(1);
					state_q <= S_DONE;
				end
				S_SCAN: begin
					chk_vld_s1 <= (issue_pos_q < count_q);
					if (scan_hit) begin
						// Drop the reads still in flight; the gap pass restarts the pipe
						chk_vld_s1 <= 1'b0;
						sh_vld_s1  <= 1'b0;
						if (op_q == OP_DELETE) begin
							state_q <= S_SHIFT;
						end else begin
							state_q <= S_DONE;
						end
					end else if (chk_vld_s1 && (chk_pos_s1 == count_q - CNT_W'(1))) begin
						chk_vld_s1 <= 1'b0;
						state_q    <= S_DONE;
					end
				end
				S_SHIFT: begin
					sh_vld_s1 <= (sh_rd_q < count_q);
					if (!(sh_rd_q < count_q) && !sh_vld_s1) begin
						sh_vld_s1 <= 1'b0;
						count_q   <= count_q - CNT_W'(1);
						state_q   <= S_DONE;
					end
				end
				S_DONE: begin
					// Hold the result until the output register frees
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= OUT_W'({OCC_W'(count_q), res_status_q, res_found_q,
							res_popped_q});
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- src/dqs_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module dqs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
